### hw/rtl/vlnu_pkg.sv
`default_nettype none
package vlnu_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int COMP_W     = 24;
	localparam int LEN_W      = 25;
	localparam int MIN_W      = 16;
	localparam int MAG_W      = 24;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SUM_W      = SQ_W + 3;
	localparam int ROOT_STEPS = (SUM_W + 1) / 2;
	localparam int ROOT_W     = ROOT_STEPS;
	localparam int NUM_W      = COMP_W + FRAC_BITS;
	localparam int DIV_STEPS  = LEN_W;
	localparam int TRIAL_W    = NUM_W + LEN_W;
	localparam int LATENCY    = 3 + ROOT_STEPS + 1 + (DIV_STEPS + 1) + 1;

	typedef enum logic [1:0] {
		CMD_LEN  = 2'd0,
		CMD_NORM = 2'd1,
		CMD_DIST = 2'd2,
		CMD_RSVD = 2'd3
	} cmd_t;

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       four_d;
		comp_t      a_x;
		comp_t      a_y;
		comp_t      a_z;
		comp_t      a_w;
		comp_t      b_x;
		comp_t      b_y;
		comp_t      b_z;
		comp_t      b_w;
	} in_t;

	typedef struct packed {
		logic [LEN_W-1:0] length_out;
		comp_t            norm_x;
		comp_t            norm_y;
		comp_t            norm_z;
		comp_t            norm_w;
		logic             did_normalize;
		logic             length_overflow;
	} out_t;

	// sideband that travels alongside the root computation
	typedef struct packed {
		logic            valid;
		cmd_t            cmd;
		logic            four_d;
		comp_t [3:0]     a;
	} side_t;

endpackage
`default_nettype wire

### hw/rtl/vlnu_sqsum.sv
`default_nettype none
module vlnu_sqsum (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  vlnu_pkg::in_t            operand,
	output vlnu_pkg::side_t          side_out,
	output logic [vlnu_pkg::SUM_W-1:0] sum_out
);
	import vlnu_pkg::*;

	side_t                     side_s1, side_s2, side_s3;
	logic signed [COMP_W:0]    d_s1 [4];
	logic [SQ_W-1:0]           sq_s2 [4];
	logic [SUM_W-1:0]          sum_s3;
	comp_t [3:0]               a_in;
	comp_t [3:0]               b_in;
	logic                      is_dist;

	assign a_in = {operand.a_w, operand.a_z, operand.a_y, operand.a_x};
	assign b_in = {operand.b_w, operand.b_z, operand.b_y, operand.b_x};
	assign is_dist = (cmd_t'(operand.cmd) == CMD_DIST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s1.valid  <= start;
			side_s1.cmd    <= cmd_t'(operand.cmd);
			side_s1.four_d <= operand.four_d;
			side_s1.a      <= a_in;
			side_s2        <= side_s1;
			side_s3        <= side_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (i == 3 && !operand.four_d)
				d_s1[i] <= '0;
			else if (is_dist)
				d_s1[i] <= (COMP_W+1)'(a_in[i]) - (COMP_W+1)'(b_in[i]);
			else
				d_s1[i] <= (COMP_W+1)'(a_in[i]);
		end
	end

	always_ff @(posedge clk) begin
		logic [MAG_W-1:0] mag;
		for (int i = 0; i < 4; i++) begin
			mag = d_s1[i][COMP_W] ? MAG_W'(-d_s1[i]) : MAG_W'(d_s1[i]);
			sq_s2[i] <= mag * mag;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]) + SUM_W'(sq_s2[3]);
	end

	assign side_out = side_s3;
	assign sum_out  = sum_s3;

endmodule
`default_nettype wire

### hw/rtl/vlnu_isqrt.sv
`default_nettype none
module vlnu_isqrt (
	input  wire                         clk,
	input  wire                         arst_n,
	input  vlnu_pkg::side_t             side_in,
	input  wire [vlnu_pkg::SUM_W-1:0]   sum_in,
	output vlnu_pkg::side_t             side_out,
	output logic [vlnu_pkg::ROOT_W-1:0] root_out
);
	import vlnu_pkg::*;

	// one result bit per stage, digit-by-digit square root
	side_t            side_s [ROOT_STEPS+1];
	logic [SUM_W-1:0] rem_s  [ROOT_STEPS+1];
	logic [SUM_W-1:0] res_s  [ROOT_STEPS+1];

	assign side_s[0] = side_in;
	assign rem_s[0]  = sum_in;
	assign res_s[0]  = '0;

	for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 1 - 2 * i);
		logic [SUM_W-1:0] trial;
		assign trial = res_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				side_s[i+1] <= '0;
			else
				side_s[i+1] <= side_s[i];
		end

		always_ff @(posedge clk) begin
			if (rem_s[i] >= trial) begin
				rem_s[i+1] <= rem_s[i] - trial;
				res_s[i+1] <= (res_s[i] >> 1) + BIT;
			end else begin
				rem_s[i+1] <= rem_s[i];
				res_s[i+1] <= res_s[i] >> 1;
			end
		end
	end

	assign side_out = side_s[ROOT_STEPS];
	assign root_out = res_s[ROOT_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

### hw/rtl/vlnu_div.sv
`default_nettype none
module vlnu_div (
	input  wire                       clk,
	input  vlnu_pkg::comp_t           a_in,
	input  wire [vlnu_pkg::LEN_W-1:0] len_in,
	output vlnu_pkg::comp_t           q_out
);
	import vlnu_pkg::*;

	// restoring divider, one quotient bit per stage; no control state
	logic [NUM_W-1:0] rem_s [DIV_STEPS+1];
	logic [LEN_W-1:0] den_s [DIV_STEPS+1];
	logic [LEN_W-1:0] q_s   [DIV_STEPS+1];
	logic             neg_s [DIV_STEPS+1];
	logic             ovf_s [DIV_STEPS+1];

	logic [COMP_W-1:0] mag;
	logic [NUM_W-1:0]  num;

	assign mag = a_in[COMP_W-1] ? COMP_W'(-a_in) : COMP_W'(a_in);
	assign num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(len_in >> 1);

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= len_in;
		q_s[0]   <= '0;
		neg_s[0] <= a_in[COMP_W-1];
		ovf_s[0] <= TRIAL_W'(num) >= (TRIAL_W'(len_in) << DIV_STEPS);
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int K = DIV_STEPS - 1 - j;
		logic [TRIAL_W-1:0] trial;
		assign trial = TRIAL_W'(den_s[j]) << K;

		always_ff @(posedge clk) begin
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
			ovf_s[j+1] <= ovf_s[j];
			if (TRIAL_W'(rem_s[j]) >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial[NUM_W-1:0];
				q_s[j+1]   <= q_s[j] | (LEN_W'(1) << K);
			end else begin
				rem_s[j+1] <= rem_s[j];
				q_s[j+1]   <= q_s[j];
			end
		end
	end

	localparam logic [LEN_W-1:0] POS_MAX = LEN_W'((1 << (COMP_W - 1)) - 1);
	localparam logic [LEN_W-1:0] NEG_MAG = LEN_W'(1 << (COMP_W - 1));

	always_comb begin
		logic [LEN_W-1:0] q;
		q = q_s[DIV_STEPS];
		if (neg_s[DIV_STEPS]) begin
			if (ovf_s[DIV_STEPS] || q > NEG_MAG)
				q_out = comp_t'(-NEG_MAG);
			else
				q_out = comp_t'(-q);
		end else begin
			if (ovf_s[DIV_STEPS] || q > POS_MAX)
				q_out = comp_t'(POS_MAX);
			else
				q_out = comp_t'(q);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/vector_length_normalize_unit.sv
`default_nettype none
// One item may start every cycle. Depth is set by the square root (one bit
// per stage, 26 stages) and the reciprocal scaling divider (one quotient bit
// per stage).
// busy is always low and the receiver cannot stall: done pulses for one cycle.
// arst_n clears min_length and the sideband pipeline; arithmetic data is not reset.
module vector_length_normalize_unit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  vlnu_pkg::in_t    operand,
	input  wire              cfg_we,
	input  wire [15:0]       cfg_wdata,
	output logic             done,
	output vlnu_pkg::out_t   result
);
	import vlnu_pkg::*;

	typedef struct packed {
		logic             valid;
		cmd_t             cmd;
		logic             four_d;
		logic             norm;
		logic             ovf;
		logic [LEN_W-1:0] len;
		comp_t [3:0]      a;
	} lside_t;

	logic [MIN_W-1:0] min_length_q;
	side_t            side_sq, side_rt;
	logic [SUM_W-1:0] sum;
	logic [ROOT_W-1:0] root;
	lside_t           lside_s [DIV_STEPS+2];
	comp_t [3:0]      scaled;
	out_t             result_q;
	logic             done_q;

	localparam logic [ROOT_W-1:0] LEN_TOP = ROOT_W'((1 << LEN_W) - 1);

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_length_q <= '0;
		else if (cfg_we)
			min_length_q <= cfg_wdata;
	end

	vlnu_sqsum u_sqsum (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.operand  (operand),
		.side_out (side_sq),
		.sum_out  (sum)
	);

	vlnu_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (side_sq),
		.sum_in   (sum),
		.side_out (side_rt),
		.root_out (root)
	);

	// length stage: saturate and decide on scaling
	always_ff @(posedge clk or negedge arst_n) begin
		logic [LEN_W-1:0] l;
		if (!arst_n) begin
			lside_s[0] <= '0;
		end else begin
			l = (root > LEN_TOP) ? LEN_TOP[LEN_W-1:0] : root[LEN_W-1:0];
			lside_s[0].valid  <= side_rt.valid;
			lside_s[0].cmd    <= side_rt.cmd;
			lside_s[0].four_d <= side_rt.four_d;
			lside_s[0].a      <= side_rt.a;
			lside_s[0].len    <= l;
			lside_s[0].ovf    <= (root > LEN_TOP);
			lside_s[0].norm   <= (l > LEN_W'(min_length_q)) && (l != '0);
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_div
		vlnu_div u_div (
			.clk    (clk),
			.a_in   (lside_s[0].a[c]),
			.len_in (lside_s[0].len),
			.q_out  (scaled[c])
		);
	end

	// sideband delay matched to the divider
	for (genvar s = 0; s <= DIV_STEPS; s++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				lside_s[s+1] <= '0;
			else
				lside_s[s+1] <= lside_s[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= lside_s[DIV_STEPS+1].valid;
	end

	always_ff @(posedge clk) begin
		lside_t      t;
		comp_t [3:0] n;
		t = lside_s[DIV_STEPS+1];
		for (int i = 0; i < 4; i++) begin
			if (t.cmd != CMD_NORM || (i == 3 && !t.four_d))
				n[i] = '0;
			else if (t.norm)
				n[i] = scaled[i];
			else
				n[i] = t.a[i];
		end
		result_q.length_out      <= t.len;
		result_q.norm_x          <= n[0];
		result_q.norm_y          <= n[1];
		result_q.norm_z          <= n[2];
		result_q.norm_w          <= n[3];
		result_q.did_normalize   <= (t.cmd == CMD_NORM) && t.norm;
		result_q.length_overflow <= t.ovf;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("item left without matching start");
	a_norm_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.did_normalize && done |-> result.length_out != '0)
		else $error("scaled with zero length");
	a_w_zero_3d: assert property (@(posedge clk) disable iff (!arst_n)
		lside_s[DIV_STEPS+1].valid && !lside_s[DIV_STEPS+1].four_d |=> result.norm_w == '0)
		else $error("w not cleared for three components");
`endif

endmodule
`default_nettype wire

### bench/vector_length_normalize_unit_checker.sv
`timescale 1ns / 1ps
module vector_length_normalize_unit_checker (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire             busy,
	input  vlnu_pkg::in_t   operand,
	input  wire             cfg_we,
	input  wire [15:0]      cfg_wdata,
	input  wire             done,
	input  vlnu_pkg::out_t  result,
	output int              fail_count,
	output int              pending
);
	import vlnu_pkg::*;

	out_t        expected_q[$];
	logic [15:0] threshold;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v   = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// round half away from zero, then clamp to 24 bit signed
	function automatic comp_t scale_to_unit(input comp_t a, input logic [63:0] len);
		logic [63:0] mag;
		logic [63:0] q;
		mag = (a < 0) ? 64'(-longint'(a)) : 64'(longint'(a));
		q   = ((mag << FRAC_BITS) + (len >> 1)) / len;
		if (a < 0)
			return (q > 64'd8388608) ? comp_t'(24'h800000) : comp_t'(-longint'(q));
		return (q > 64'd8388607) ? comp_t'(24'sd8388607) : comp_t'(q);
	endfunction

	function automatic out_t predict_length(input in_t op, input logic [15:0] thr);
		out_t        r;
		longint      a[4];
		longint      b[4];
		longint      d;
		logic [63:0] sum;
		logic [63:0] len;
		int          n;
		a   = '{op.a_x, op.a_y, op.a_z, op.a_w};
		b   = '{op.b_x, op.b_y, op.b_z, op.b_w};
		n   = op.four_d ? 4 : 3;
		sum = 0;
		for (int i = 0; i < n; i++) begin
			d   = (op.cmd == CMD_DIST) ? a[i] - b[i] : a[i];
			if (d < 0)
				d = -d;
			sum = sum + 64'(d) * 64'(d);
		end
		len = int_sqrt(sum);
		r   = '0;
		if (len > 64'h1FFFFFF) begin
			len               = 64'h1FFFFFF;
			r.length_overflow = 1'b1;
		end
		r.length_out = len[LEN_W-1:0];
		if (op.cmd == CMD_NORM) begin
			if (len > 64'(thr) && len != 0) begin
				r.norm_x        = scale_to_unit(op.a_x, len);
				r.norm_y        = scale_to_unit(op.a_y, len);
				r.norm_z        = scale_to_unit(op.a_z, len);
				if (op.four_d)
					r.norm_w = scale_to_unit(op.a_w, len);
				r.did_normalize = 1'b1;
			end else begin
				r.norm_x = op.a_x;
				r.norm_y = op.a_y;
				r.norm_z = op.a_z;
				if (op.four_d)
					r.norm_w = op.a_w;
			end
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_t exp_r;
		if (!arst_n) begin
			threshold  <= '0;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no item outstanding");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (result !== exp_r) begin
						fail_count <= fail_count + 1;
						if (result.length_out !== exp_r.length_out)
							$error("length_out exp %0d got %0d", exp_r.length_out,
								result.length_out);
						if (result.norm_x !== exp_r.norm_x)
							$error("norm_x exp %0d got %0d", exp_r.norm_x, result.norm_x);
						if (result.norm_y !== exp_r.norm_y)
							$error("norm_y exp %0d got %0d", exp_r.norm_y, result.norm_y);
						if (result.norm_z !== exp_r.norm_z)
							$error("norm_z exp %0d got %0d", exp_r.norm_z, result.norm_z);
						if (result.norm_w !== exp_r.norm_w)
							$error("norm_w exp %0d got %0d", exp_r.norm_w, result.norm_w);
						if (result.did_normalize !== exp_r.did_normalize)
							$error("did_normalize exp %0d got %0d", exp_r.did_normalize,
								result.did_normalize);
						if (result.length_overflow !== exp_r.length_overflow)
							$error("length_overflow exp %0d got %0d", exp_r.length_overflow,
								result.length_overflow);
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(predict_length(operand, threshold));
			if (cfg_we)
				threshold <= cfg_wdata;
		end
	end

endmodule

### bench/vector_length_normalize_unit_tb.sv
`timescale 1ns / 1ps
module vector_length_normalize_unit_tb;
	import vlnu_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	in_t         operand = '0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        done;
	out_t        result;
	int          fail_count;
	int          pending;
	int          cycles = 0;

	localparam int CYCLE_LIMIT = 200000;

	always #1 clk = ~clk;

	vector_length_normalize_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operand  (operand),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.done     (done),
		.result   (result)
	);

	vector_length_normalize_unit_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operand   (operand),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic comp_t rand_comp(input int mode);
		case (mode)
			0: return comp_t'($urandom);
			1: return comp_t'($urandom_range(0, 2 * 65536)) - comp_t'(65536);
			2: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
			default: begin
				case ($urandom_range(0, 3))
					0: return comp_t'(24'h7FFFFF);
					1: return comp_t'(24'h800000);
					2: return comp_t'(0);
					default: return comp_t'(-1);
				endcase
			end
		endcase
	endfunction

	function automatic in_t rand_item();
		in_t op;
		int  mode;
		mode      = $urandom_range(0, 3);
		op.cmd    = $urandom_range(0, 9) == 0 ? 2'(CMD_RSVD) : 2'($urandom_range(0, 2));
		op.four_d = 1'($urandom);
		op.a_x    = rand_comp(mode);
		op.a_y    = rand_comp(mode);
		op.a_z    = rand_comp(mode);
		op.a_w    = rand_comp(mode);
		op.b_x    = rand_comp(mode);
		op.b_y    = rand_comp(mode);
		op.b_z    = rand_comp(mode);
		op.b_w    = rand_comp(mode);
		return op;
	endfunction

	// one item, handed over at a falling edge, taken at the next rising edge
	task automatic send_item(input in_t op, input bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			gap   = $urandom_range(1, 15);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		operand <= op;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic directed_item(input cmd_t c, input bit f, input comp_t v, input comp_t bv);
		in_t op;
		op.cmd    = c;
		op.four_d = f;
		op.a_x    = v;
		op.a_y    = v;
		op.a_z    = v;
		op.a_w    = v;
		op.b_x    = bv;
		op.b_y    = bv;
		op.b_z    = bv;
		op.b_w    = bv;
		send_item(op, 1'b0);
	endtask

	initial begin
		logic [15:0] settings[5];
		settings = '{16'd0, 16'hFFFF, 16'd32768, 16'd40, 16'd0};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_item(CMD_LEN, 1'b0, comp_t'(0), comp_t'(0));
		directed_item(CMD_NORM, 1'b0, comp_t'(0), comp_t'(0));
		directed_item(CMD_LEN, 1'b1, comp_t'(24'h7FFFFF), comp_t'(0));
		directed_item(CMD_LEN, 1'b1, comp_t'(24'h800000), comp_t'(0));
		directed_item(CMD_NORM, 1'b1, comp_t'(24'h800000), comp_t'(0));
		directed_item(CMD_NORM, 1'b0, comp_t'(24'h7FFFFF), comp_t'(24'h800000));
		directed_item(CMD_NORM, 1'b1, comp_t'(1), comp_t'(0));
		directed_item(CMD_NORM, 1'b1, comp_t'(-1), comp_t'(0));
		directed_item(CMD_DIST, 1'b1, comp_t'(24'h7FFFFF), comp_t'(24'h800000));
		directed_item(CMD_DIST, 1'b0, comp_t'(24'h800000), comp_t'(24'h7FFFFF));
		directed_item(CMD_DIST, 1'b1, comp_t'(5), comp_t'(5));
		directed_item(CMD_RSVD, 1'b1, comp_t'(65536), comp_t'(-65536));
		directed_item(CMD_RSVD, 1'b0, comp_t'(-65536), comp_t'(3));
		drain();
		// short and long vectors at the top threshold
		write_threshold(16'hFFFF);
		directed_item(CMD_NORM, 1'b1, comp_t'(65536 / 2), comp_t'(0));
		directed_item(CMD_NORM, 1'b0, comp_t'(24'h800000), comp_t'(0));
		directed_item(CMD_NORM, 1'b1, comp_t'(-20000), comp_t'(0));
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			write_threshold(settings[phase]);
			for (int n = 0; n < 260; n++)
				send_item(rand_item(), phase < 4);
			drain();
		end

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
